FILE: rtl/fexp_pkg.sv
// Package for the float32 exponential unit: types, constants and float32 arithmetic functions.
`default_nettype none
package fexp_pkg;

    localparam int unsigned NumCells = 22;

    localparam logic [31:0] CLn2Hi   = 32'hBF317200; // -0.693145751953125
    localparam logic [31:0] CLn2Lo   = 32'hB5BFBE8E; // -1.4286067653e-06
    localparam logic [31:0] CLog2e   = 32'h3FB8AA3B;
    localparam logic [31:0] CP0      = 32'h39502BDA; // 0.0001985276
    localparam logic [31:0] CP1      = 32'h3AB696C9; // 0.0013930436
    localparam logic [31:0] CP2      = 32'h3C0888A6; // 0.0083333608
    localparam logic [31:0] CP3      = 32'h3D2AAA7A; // 0.0416664854
    localparam logic [31:0] CP4      = 32'h3E2AAAAB; // 0.1666666716
    localparam logic [31:0] CHalf    = 32'h3F000000;
    localparam logic [31:0] CNegHalf = 32'hBF000000;
    localparam logic [31:0] COne     = 32'h3F800000;
    localparam logic [31:0] CPosInf  = 32'h7F800000;
    localparam logic [8:0]  ExpBias  = 9'd127;

    // Operation that each cell of the chain carries out, in chain order.
    typedef enum logic [4:0] {
        ST_MUL_LOG2E,
        ST_ROUND,
        ST_MUL_Q_HI,
        ST_ADD_HI,
        ST_MUL_Q_LO,
        ST_ADD_LO,
        ST_H1_MUL,
        ST_H1_ADD,
        ST_H2_MUL,
        ST_H2_ADD,
        ST_H3_MUL,
        ST_H3_ADD,
        ST_H4_MUL,
        ST_H4_ADD,
        ST_H5_MUL,
        ST_H5_ADD,
        ST_SQUARE,
        ST_MUL_TU,
        ST_ADD_TS,
        ST_ADD_ONE,
        ST_SCALE1,
        ST_SCALE2
    } step_t;

    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic [31:0] x;
        logic [31:0] a;
        logic [31:0] s;
        logic [31:0] u;
        logic [8:0]  q;
    } lane_t;

    // Float32 multiply with round to nearest even, subnormals per IEEE.
    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic        sgn;
        logic [7:0]  ea, eb;
        logic [23:0] ma, mb;
        logic [47:0] p;
        logic signed [11:0] e;
        logic [5:0]  lz;
        logic [49:0] w;
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [31:0] r;
        logic signed [11:0] sh;
        logic [73:0] ext;
        logic [23:0] mant;
        logic        g, st, rnd;
        logic [24:0] mr;
        logic signed [11:0] ef;
        sgn = a[31] ^ b[31];
        ea = a[30:23]; eb = b[30:23];
        nan_a = (ea == 8'hFF) && (a[22:0] != 0);
        nan_b = (eb == 8'hFF) && (b[22:0] != 0);
        inf_a = (ea == 8'hFF) && (a[22:0] == 0);
        inf_b = (eb == 8'hFF) && (b[22:0] == 0);
        zero_a = (a[30:0] == 0);
        zero_b = (b[30:0] == 0);
        ma = {(ea != 0), a[22:0]};
        mb = {(eb != 0), b[22:0]};
        p = ma * mb;
        e = 12'(signed'({4'd0, (ea == 0) ? 8'd1 : ea})) +
            12'(signed'({4'd0, (eb == 0) ? 8'd1 : eb})) - 12'sd127;
        lz = 6'd48;
        for (int i = 0; i < 48; i++)
            if (p[i]) lz = 6'(47 - i);
        // value = p * 2^(e-127-46); normalise so leading bit at 47
        w = 50'(p) << lz;
        ef = e + 12'sd1 - 12'(signed'({6'd0, lz}));
        // w[47] leading; exponent ef
        if (ef >= 12'sd1) begin
            sh = 12'sd0;
        end else begin
            sh = 12'sd1 - ef;
            ef = 12'sd0;
        end
        ext = {w[47:0], 26'd0};
        if (sh > 12'sd60)
            ext = {73'd0, |w};
        else
            ext = (ext >> sh) | 74'(|(ext & ((74'd1 << sh) - 74'd1)));
        mant = ext[73:50];
        g = ext[49];
        st = |ext[48:0];
        rnd = g && (st || mant[0]);
        mr = {1'b0, mant} + 25'(rnd);
        if (mr[24]) begin
            mr = mr >> 1;
            ef = ef + 12'sd1;
        end else if (ef == 12'sd0 && mr[23]) begin
            ef = 12'sd1;
        end
        if (ef >= 12'sd255)
            r = {sgn, 31'h7F800000};
        else
            r = {sgn, ef[7:0], mr[22:0]};
        if (nan_a) r = a | 32'h00400000;
        else if (nan_b) r = b | 32'h00400000;
        else if ((inf_a && zero_b) || (inf_b && zero_a)) r = 32'h7FC00000;
        else if (inf_a || inf_b) r = {sgn, 31'h7F800000};
        else if (zero_a || zero_b) r = {sgn, 31'd0};
        return r;
    endfunction

    // Float32 add with round to nearest even.
    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big, sml, r;
        logic [7:0]  eb_, es_;
        logic [26:0] mb_, ms_;
        logic [7:0]  d;
        logic [27:0] sum;
        logic [4:0]  lz;
        logic signed [9:0] e;
        logic        sub, g, st, rnd;
        logic [24:0] mr;
        logic [27:0] n;
        if (a[30:0] >= b[30:0]) begin big = a; sml = b; end
        else begin big = b; sml = a; end
        eb_ = big[30:23]; es_ = sml[30:23];
        mb_ = {(eb_ != 0), big[22:0], 3'd0};
        ms_ = {(es_ != 0), sml[22:0], 3'd0};
        d = ((eb_ == 0) ? 8'd1 : eb_) - ((es_ == 0) ? 8'd1 : es_);
        if (d > 8'd26)
            ms_ = {26'd0, |ms_};
        else
            ms_ = (ms_ >> d) | 27'(|(ms_ & ((27'd1 << d) - 27'd1)));
        sub = a[31] ^ b[31];
        sum = sub ? ({1'b0, mb_} - {1'b0, ms_}) : ({1'b0, mb_} + {1'b0, ms_});
        e = 10'(signed'({2'd0, (eb_ == 0) ? 8'd1 : eb_}));
        if (sum[27]) begin
            n = {1'b0, sum[27:2], |sum[1:0]};
            e = e + 10'sd1;
        end else begin
            lz = 5'd27;
            for (int i = 0; i < 27; i++)
                if (sum[i]) lz = 5'(26 - i);
            if (10'(signed'({5'd0, lz})) > e - 10'sd1)
                lz = 5'(e - 10'sd1);
            n = sum << lz;
            e = e - 10'(signed'({5'd0, lz}));
            if (!n[26]) e = 10'sd0;
        end
        g = n[2];
        st = |n[1:0];
        rnd = g && (st || n[3]);
        mr = {1'b0, n[26:3]} + 25'(rnd);
        if (mr[24]) begin
            mr = mr >> 1;
            e = e + 10'sd1;
        end else if (e == 10'sd0 && mr[23]) begin
            e = 10'sd1;
        end
        if (e >= 10'sd255) r = {big[31], 31'h7F800000};
        else r = {big[31], e[7:0], mr[22:0]};
        if (sum == 28'd0) r = (a[31] & b[31]) ? 32'h80000000 : 32'h0;
        if (eb_ == 8'hFF) begin
            if (big[22:0] != 0) r = big | 32'h00400000;
            else if (es_ == 8'hFF && sml[22:0] != 0) r = sml | 32'h00400000;
            else if (es_ == 8'hFF && sub) r = 32'h7FC00000;
            else r = big;
        end
        return r;
    endfunction

    // Truncation of a float (|x| < 256) to a signed 9-bit integer.
    function automatic logic [8:0] ftoi(input logic [31:0] a);
        logic [7:0]  e;
        logic [31:0] m;
        logic [8:0]  v;
        e = a[30:23];
        m = {8'd0, 1'b1, a[22:0]};
        if (e < 8'd127) v = 9'd0;
        else v = 9'(m >> (8'd150 - e));
        return a[31] ? 9'(-v) : v;
    endfunction

    // Signed 9-bit integer to float (exact).
    function automatic logic [31:0] itof(input logic [8:0] q);
        logic [8:0]  m;
        logic [3:0]  p;
        logic [22:0] f;
        m = q[8] ? 9'(-q) : q;
        p = 4'd0;
        for (int i = 0; i < 9; i++)
            if (m[i]) p = 4'(i);
        f = 23'({14'd0, m} << (5'd23 - 5'(p)));
        return (m == 0) ? 32'd0 : {q[8], 8'(8'd127 + 8'(p)), f};
    endfunction

    function automatic logic [31:0] pow2(input logic [8:0] e);
        logic [8:0] f;
        f = e + ExpBias;
        return {1'b0, f[7:0], 23'd0};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fexp_cell.sv
// One step of the exponential chain: a single float32 operation on the lane, then a register.
`default_nettype none
module fexp_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fexp_pkg::step_t step,
    input  wire logic            en,
    input  wire logic            vin,
    input  wire fexp_pkg::lane_t lin,
    output logic                 vout,
    output fexp_pkg::lane_t      lout
);
    import fexp_pkg::*;

    lane_t nxt;
    logic [31:0] coef;
    logic [8:0]  q1;

    always_comb
    begin
        nxt = lin;
        q1 = 9'($signed(lin.q) / 2);
        unique case (step)
            ST_H1_ADD: coef = CP1;
            ST_H2_ADD: coef = CP2;
            ST_H3_ADD: coef = CP3;
            ST_H4_ADD: coef = CP4;
            default:   coef = CHalf;
        endcase
        unique case (step)
            ST_MUL_LOG2E: nxt.a = fmul(lin.x, CLog2e);
            ST_ROUND:     nxt.q = ftoi(fadd(lin.a, lin.a[31] ? CNegHalf : CHalf));
            ST_MUL_Q_HI:  nxt.a = fmul(itof(lin.q), CLn2Hi);
            ST_ADD_HI:    nxt.s = fadd(lin.a, lin.x);
            ST_MUL_Q_LO:  nxt.a = fmul(itof(lin.q), CLn2Lo);
            ST_ADD_LO:
            begin
                nxt.s = fadd(lin.a, lin.s);
                nxt.u = CP0;
            end
            ST_H1_MUL, ST_H2_MUL, ST_H3_MUL, ST_H4_MUL, ST_H5_MUL:
                nxt.u = fmul(lin.u, lin.s);
            ST_H1_ADD, ST_H2_ADD, ST_H3_ADD, ST_H4_ADD, ST_H5_ADD:
                nxt.u = fadd(lin.u, coef);
            ST_SQUARE:    nxt.a = fmul(lin.s, lin.s);
            ST_MUL_TU:    nxt.a = fmul(lin.a, lin.u);
            ST_ADD_TS:    nxt.a = fadd(lin.a, lin.s);
            ST_ADD_ONE:   nxt.u = fadd(COne, lin.a);
            ST_SCALE1:    nxt.u = fmul(lin.u, pow2(q1));
            ST_SCALE2:    nxt.u = fmul(lin.u, pow2(9'(lin.q - q1)));
            default:      nxt = lin;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout <= 1'b0;
        else if (en)
            vout <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lout <= nxt;
    end
endmodule
`default_nettype wire

FILE: rtl/float32_exp_unit_core.sv
// Top level of the float32 exponential unit: range check, chain of cells and output stage.
// Each cell of the 22-cell chain does one float32 operation; the output register follows.
// Throughput: one item per cycle while the output is not stalled.
// A stall on the output holds the whole chain; input tready follows the output stage.
// Reset clears the valid bits of every cell; payload registers are not reset.
`default_nettype none
module float32_exp_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // operand_bits[31:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // result_bits[31:0]
);
    import fexp_pkg::*;

    logic   v [NumCells+1];
    lane_t  l [NumCells+1];
    logic   en;
    logic   in_nan, in_low, in_high;
    logic [31:0] x;
    logic   out_v_reg;
    logic [31:0] out_d_reg;

    assign x = s_axis_tdata;
    assign in_nan = (x[30:23] == 8'hFF) && (x[22:0] != 0);
    // Below -104 means negative with magnitude above 0x42D00000; above 100 is over 0x42C80000.
    assign in_low  = x[31] && (x[30:0] > 31'h42D00000);
    assign in_high = !x[31] && (x[30:0] > 31'h42C80000) && !in_nan;

    assign en = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        v[0] = s_axis_tvalid;
        l[0] = '0;
        l[0].x = (in_nan || in_low || in_high) ? 32'd0 : x;
        l[0].special = in_nan || in_low || in_high;
        l[0].special_val = in_nan ? x : (in_low ? 32'd0 : CPosInf);
    end

    for (genvar i = 0; i < NumCells; i++)
    begin : g_cell
        fexp_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .step (step_t'(i)),
            .en   (en),
            .vin  (v[i]),
            .lin  (l[i]),
            .vout (v[i+1]),
            .lout (l[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= v[NumCells];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_d_reg <= l[NumCells].special ? l[NumCells].special_val : l[NumCells].u;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output stage");
    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        en && v[NumCells] |=> m_axis_tvalid)
        else $error("chain output lost");
endmodule
`default_nettype wire
